### src/spring_layout_derivative_accumulator_assert.svh
// assertion macros for the spring layout derivative accumulator
`ifndef SPRING_LAYOUT_DERIVATIVE_ACCUMULATOR_ASSERT_SVH
`define SPRING_LAYOUT_DERIVATIVE_ACCUMULATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SLD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define SLD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/sldacc_pkg.sv
// shared widths, types and saturation helpers of the derivative accumulator
package sldacc_pkg;

	localparam int COORD_W = 32;
	localparam int PARAM_W = 32;
	localparam int SUM_W   = 48;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int ROOT_W  = 34;
	localparam int SQ_W    = 2 * DIFF_W;
	localparam int RAD_W   = SQ_W + 1;
	localparam int WIDE_W  = 98;
	localparam int ADD_W   = WIDE_W + 2;
	localparam int Q_W     = 33;
	localparam int KL_W    = 2 * PARAM_W;
	localparam int FRAC_W  = 16;
	localparam int CNT_W   = 7;

	localparam int MUL_STEPS  = ROOT_W;
	localparam int DIV_STEPS  = WIDE_W;
	localparam int SQRT_STEPS = ROOT_W;

	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic [WIDE_W-1:0] wide_t;

	localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// signed value from sign and magnitude, clipped to the sum range
	function automatic sum_t sat_mag(input logic neg, input wide_t mag);
		sum_t res;
		if (|mag[WIDE_W-1:SUM_W-1]) begin
			res = neg ? SUM_MIN : SUM_MAX;
		end else if (neg) begin
			res = sum_t'(-mag[SUM_W-1:0]);
		end else begin
			res = sum_t'(mag[SUM_W-1:0]);
		end
		return res;
	endfunction

	// saturating add in the sum range
	function automatic sum_t sat_add(input sum_t a, input sum_t b);
		logic [SUM_W:0] s;
		sum_t res;
		s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
		if (s[SUM_W] != s[SUM_W-1]) begin
			res = s[SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			res = sum_t'(s[SUM_W-1:0]);
		end
		return res;
	endfunction

endpackage

### src/spring_layout_derivative_accumulator.sv
// spring layout energy gradient and hessian accumulator, one vertex pair per item
//
// Each item is one pair: the moving vertex, another vertex, the spring strength and
// rest length. The pair's gradient (x, y) and hessian (xx, yy, xy) terms are added
// to five saturating Q31.16 sums; the item flagged last releases the five sums as a
// result and clears them. All arithmetic runs on one shared 100-bit add/subtract
// unit: a shift-add multiply, a restoring divide and a square root take turns on
// it. A pair at nonzero distance needs 11 multiplies, 8 divides and one root,
// and the next item is taken only once all of them are done; a pair at zero
// distance skips the arithmetic. item_ready is high only while the block
// waits for a pair; the result sits in an output register, so a new pair is taken
// while it waits, and only a following last pair stalls until it has been taken.
module spring_layout_derivative_accumulator (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_ready,
	input  logic signed [sldacc_pkg::COORD_W-1:0] own_x,
	input  logic signed [sldacc_pkg::COORD_W-1:0] own_y,
	input  logic signed [sldacc_pkg::COORD_W-1:0] other_x,
	input  logic signed [sldacc_pkg::COORD_W-1:0] other_y,
	input  logic        [sldacc_pkg::PARAM_W-1:0] spring_k,
	input  logic        [sldacc_pkg::PARAM_W-1:0] rest_len,
	input  logic                                  last,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output logic signed [sldacc_pkg::SUM_W-1:0]   grad_x,
	output logic signed [sldacc_pkg::SUM_W-1:0]   grad_y,
	output logic signed [sldacc_pkg::SUM_W-1:0]   hess_xx,
	output logic signed [sldacc_pkg::SUM_W-1:0]   hess_yy,
	output logic signed [sldacc_pkg::SUM_W-1:0]   hess_xy
);
	import sldacc_pkg::*;

	typedef enum logic [1:0] {OP_MUL, OP_DIV, OP_SQRT} op_t;
	typedef enum logic [1:0] {PH_LOAD, PH_RUN, PH_STORE} phase_t;
	typedef enum logic [4:0] {
		ST_IDLE, ST_X2, ST_Y2, ST_XY, ST_ROOT, ST_KL, ST_KAX, ST_KAY,
		ST_NUMX, ST_GX, ST_NUMY, ST_GY, ST_QX, ST_MYY, ST_HYY, ST_QY,
		ST_MXX, ST_HXX, ST_QXY, ST_MXY, ST_HXY, ST_DONE
	} step_t;

	step_t  step_q;
	phase_t phase_q;
	op_t    e_op_q;

	// latched pair
	logic [DIFF_W-1:0]  ax_q, ay_q;
	logic               negx_q, negy_q, last_q;
	logic [PARAM_W-1:0] k_q, l_q;

	// intermediate values
	logic [SQ_W-1:0]   x2_q, y2_q, xy_q;
	logic [RAD_W-1:0]  s_q;
	logic [ROOT_W-1:0] d_q, dl_q;
	logic              short_q;
	logic [KL_W-1:0]   kl_q, kax_q, kay_q;
	wide_t             num_q;
	logic [Q_W-1:0]    q_q;

	// shared unit registers
	wide_t             e_a_q, e_r_q;
	logic [RAD_W-1:0]  e_b_q;
	logic [CNT_W-1:0]  e_cnt_q;

	sum_t acc_gx_q, acc_gy_q, acc_hxx_q, acc_hyy_q, acc_hxy_q;
	sum_t out_gx_q, out_gy_q, out_hxx_q, out_hyy_q, out_hxy_q;
	logic out_valid_q;

	// input differences as sign and magnitude
	logic signed [DIFF_W-1:0] dx, dy;
	logic [DIFF_W-1:0]        mag_x, mag_y;
	assign dx    = {own_x[COORD_W-1], own_x} - {other_x[COORD_W-1], other_x};
	assign dy    = {own_y[COORD_W-1], own_y} - {other_y[COORD_W-1], other_y};
	assign mag_x = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
	assign mag_y = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);

	assign item_ready = (step_q == ST_IDLE);

	// operand selection for the step being loaded
	op_t              ld_op;
	wide_t            ld_a;
	logic [RAD_W-1:0] ld_b;
	always_comb begin
		ld_op = OP_MUL;
		ld_a  = '0;
		ld_b  = '0;
		unique case (step_q)
			ST_X2:   begin ld_a = WIDE_W'(ax_q); ld_b = RAD_W'(ax_q); end
			ST_Y2:   begin ld_a = WIDE_W'(ay_q); ld_b = RAD_W'(ay_q); end
			ST_XY:   begin ld_a = WIDE_W'(ax_q); ld_b = RAD_W'(ay_q); end
			ST_ROOT: begin ld_op = OP_SQRT; ld_a = WIDE_W'(s_q); end
			ST_KL:   begin ld_a = WIDE_W'(k_q); ld_b = RAD_W'(l_q); end
			ST_KAX:  begin ld_a = WIDE_W'(k_q); ld_b = RAD_W'(ax_q); end
			ST_KAY:  begin ld_a = WIDE_W'(k_q); ld_b = RAD_W'(ay_q); end
			ST_NUMX: begin ld_a = WIDE_W'(kax_q); ld_b = RAD_W'(dl_q); end
			ST_NUMY: begin ld_a = WIDE_W'(kay_q); ld_b = RAD_W'(dl_q); end
			ST_MYY, ST_MXX, ST_MXY: begin
				ld_a = WIDE_W'(kl_q); ld_b = RAD_W'(q_q);
			end
			ST_GX, ST_GY, ST_HYY, ST_HXX, ST_HXY: begin
				ld_op = OP_DIV; ld_a = num_q; ld_b = RAD_W'(d_q);
			end
			ST_QX:   begin ld_op = OP_DIV; ld_a = {x2_q, 32'd0}; ld_b = s_q; end
			ST_QY:   begin ld_op = OP_DIV; ld_a = {y2_q, 32'd0}; ld_b = s_q; end
			ST_QXY:  begin ld_op = OP_DIV; ld_a = {xy_q, 32'd0}; ld_b = s_q; end
			default: begin ld_op = OP_MUL; end
		endcase
	end

	// shared add/subtract unit
	logic [ADD_W-1:0] add_x, add_y, add_sum;
	logic             add_sub, borrow;
	always_comb begin
		unique case (e_op_q)
			OP_DIV: begin
				add_x   = ADD_W'({e_r_q[RAD_W-1:0], e_a_q[WIDE_W-1]});
				add_y   = ADD_W'(e_b_q);
				add_sub = 1'b1;
			end
			OP_SQRT: begin
				add_x   = ADD_W'({e_r_q[ROOT_W:0], e_a_q[RAD_W:RAD_W-1]});
				add_y   = ADD_W'({e_b_q[ROOT_W-1:0], 2'b01});
				add_sub = 1'b1;
			end
			default: begin
				add_x   = ADD_W'(e_r_q);
				add_y   = ADD_W'(e_a_q);
				add_sub = 1'b0;
			end
		endcase
		add_sum = add_x + (add_y ^ {ADD_W{add_sub}}) + ADD_W'(add_sub);
		borrow  = add_sum[ADD_W-1];
	end

	// root compared against rest length
	logic [ROOT_W-1:0] root, len_ext;
	logic              root_short;
	assign root       = e_b_q[ROOT_W-1:0];
	assign len_ext    = ROOT_W'(l_q);
	assign root_short = root < len_ext;

	// term of a diagonal hessian entry: k minus the scaled quotient
	logic [SQ_W-1:0] diag_t;
	sum_t            diag_term;
	always_comb begin
		diag_t = e_a_q[WIDE_W-1:32];
		if (diag_t <= SQ_W'(k_q)) begin
			diag_term = sum_t'(SQ_W'(k_q) - diag_t);
		end else begin
			diag_term = sat_mag(1'b1, WIDE_W'(diag_t - SQ_W'(k_q)));
		end
	end

	// gradient sign follows the axis of the step
	sum_t gterm, hxy_term;
	assign gterm    = sat_mag(((step_q == ST_GY) ? negy_q : negx_q) ^ short_q,
		e_a_q >> FRAC_W);
	assign hxy_term = sat_mag(negx_q ^ negy_q, e_a_q >> 32);

	// sequencer, shared unit and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE; phase_q <= PH_LOAD; e_op_q <= OP_MUL;
			ax_q <= '0; ay_q <= '0; negx_q <= 1'b0; negy_q <= 1'b0; last_q <= 1'b0;
			k_q <= '0; l_q <= '0;
			x2_q <= '0; y2_q <= '0; xy_q <= '0; s_q <= '0; d_q <= '0; dl_q <= '0;
			short_q <= 1'b0; kl_q <= '0; kax_q <= '0; kay_q <= '0; num_q <= '0; q_q <= '0;
			e_a_q <= '0; e_r_q <= '0; e_b_q <= '0; e_cnt_q <= '0;
			acc_gx_q <= '0; acc_gy_q <= '0; acc_hxx_q <= '0; acc_hyy_q <= '0;
			acc_hxy_q <= '0;
			out_gx_q <= '0; out_gy_q <= '0; out_hxx_q <= '0; out_hyy_q <= '0;
			out_hxy_q <= '0; out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && result_ready && !(step_q == ST_DONE && last_q)) begin
				out_valid_q <= 1'b0;
			end
			unique case (step_q)
				ST_IDLE: begin
					if (item_valid) begin
						ax_q <= mag_x; ay_q <= mag_y;
						negx_q <= dx[DIFF_W-1]; negy_q <= dy[DIFF_W-1];
						k_q <= spring_k; l_q <= rest_len; last_q <= last;
						phase_q <= PH_LOAD;
						step_q <= (dx == '0 && dy == '0) ? ST_DONE : ST_X2;
					end
				end
				ST_DONE: begin
					if (!last_q) begin
						step_q <= ST_IDLE;
					end else if (!out_valid_q || result_ready) begin
						out_gx_q <= acc_gx_q; out_gy_q <= acc_gy_q;
						out_hxx_q <= acc_hxx_q; out_hyy_q <= acc_hyy_q;
						out_hxy_q <= acc_hxy_q; out_valid_q <= 1'b1;
						acc_gx_q <= '0; acc_gy_q <= '0; acc_hxx_q <= '0;
						acc_hyy_q <= '0; acc_hxy_q <= '0;
						step_q <= ST_IDLE;
					end
				end
				default: begin
					unique case (phase_q)
						PH_LOAD: begin
							e_op_q <= ld_op; e_a_q <= ld_a; e_b_q <= ld_b; e_r_q <= '0;
							unique case (ld_op)
								OP_DIV:  e_cnt_q <= CNT_W'(DIV_STEPS - 1);
								OP_SQRT: e_cnt_q <= CNT_W'(SQRT_STEPS - 1);
								default: e_cnt_q <= CNT_W'(MUL_STEPS - 1);
							endcase
							phase_q <= PH_RUN;
						end
						PH_RUN: begin
							// one bit of multiply or divide, or one root digit
							unique case (e_op_q)
								OP_DIV: begin
									e_r_q <= borrow ? WIDE_W'(add_x[RAD_W:0])
										: WIDE_W'(add_sum[RAD_W:0]);
									e_a_q <= {e_a_q[WIDE_W-2:0], ~borrow};
								end
								OP_SQRT: begin
									e_r_q <= borrow ? WIDE_W'(add_x[ROOT_W+2:0])
										: WIDE_W'(add_sum[ROOT_W+2:0]);
									e_b_q <= {e_b_q[RAD_W-2:0], ~borrow};
									e_a_q <= e_a_q << 2;
								end
								default: begin
									if (e_b_q[0]) begin
										e_r_q <= add_sum[WIDE_W-1:0];
									end
									e_a_q <= e_a_q << 1;
									e_b_q <= e_b_q >> 1;
								end
							endcase
							if (e_cnt_q == '0) begin
								phase_q <= PH_STORE;
							end else begin
								e_cnt_q <= e_cnt_q - 1'b1;
							end
						end
						default: begin
							// take the result and move to the next step
							phase_q <= PH_LOAD;
							step_q  <= step_t'(step_q + 1'b1);
							unique case (step_q)
								ST_X2: x2_q <= e_r_q[SQ_W-1:0];
								ST_Y2: begin
									y2_q <= e_r_q[SQ_W-1:0];
									s_q  <= RAD_W'(x2_q) + RAD_W'(e_r_q[SQ_W-1:0]);
								end
								ST_XY: xy_q <= e_r_q[SQ_W-1:0];
								ST_ROOT: begin
									d_q     <= root;
									short_q <= root_short;
									dl_q    <= root_short ? len_ext - root : root - len_ext;
								end
								ST_KL:  kl_q  <= e_r_q[KL_W-1:0];
								ST_KAX: kax_q <= e_r_q[KL_W-1:0];
								ST_KAY: kay_q <= e_r_q[KL_W-1:0];
								ST_GX:  acc_gx_q <= sat_add(acc_gx_q, gterm);
								ST_GY:  acc_gy_q <= sat_add(acc_gy_q, gterm);
								ST_QX, ST_QY, ST_QXY: q_q <= e_a_q[Q_W-1:0];
								ST_HYY: acc_hyy_q <= sat_add(acc_hyy_q, diag_term);
								ST_HXX: acc_hxx_q <= sat_add(acc_hxx_q, diag_term);
								ST_HXY: acc_hxy_q <= sat_add(acc_hxy_q, hxy_term);
								default: num_q <= e_r_q;
							endcase
						end
					endcase
				end
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign grad_x  = out_gx_q;
	assign grad_y  = out_gy_q;
	assign hess_xx = out_hxx_q;
	assign hess_yy = out_hyy_q;
	assign hess_xy = out_hxy_q;

	`include "spring_layout_derivative_accumulator_assert.svh"

	`SLD_ASSERT_NEXT(a_busy_after_accept, item_valid && item_ready, !item_ready, "ready after accept")
	`SLD_ASSERT_NOW(a_cleared_on_result, $rose(result_valid), acc_gx_q == '0 && acc_hxy_q == '0, "sums kept after result")
	`SLD_ASSERT_NOW(a_root_nonzero, step_q == ST_GX && phase_q == PH_LOAD, d_q != '0, "zero distance root")

endmodule
